// ----- sv/ncm_pkg.sv -----
// Shared constants and the squared threshold table for the normalization cube-map core.
`default_nettype none

package ncm_pkg;

   // Each color component is an unsigned code of this many bits.
   localparam int CODE_BITS = 8;
   localparam int ENC_STAGES = 2 * CODE_BITS;
   localparam logic [CODE_BITS-1:0] HALF_CODE = CODE_BITS'(2 ** (CODE_BITS - 1));

   // Width of the squared threshold term (2*m - 2**CODE_BITS)**2.
   localparam int BSQ_W = 2 * CODE_BITS + 1;

   localparam int FACE_SIZE_W = 11;
   localparam logic [FACE_SIZE_W-1:0] FACE_SIZE_RESET = 11'd256;
   localparam int DEFAULT_MAX_FACE_SIZE = 1024;

   typedef logic [BSQ_W-1:0] bsq_table_type [2 ** CODE_BITS];

   function automatic bsq_table_type build_bterm_sq();
      bsq_table_type tbl;
      int d;
      for (int i = 0; i < 2 ** CODE_BITS; i++) begin
         d = 2 * i - 2 ** CODE_BITS;
         tbl[i] = BSQ_W'(d * d);
      end
      return tbl;
   endfunction

   localparam bsq_table_type BTERM_SQ = build_bterm_sq();

endpackage

`default_nettype wire

// ----- sv/normalization_cubemap_texel_core.sv -----
// Top level of the normalization cube-map texel generator.
//
//   channel   ports                              direction  handshake
//   request   start, busy, req_face/column/row   in         start && !busy
//   response  rsp_valid, rsp_red..coord_error    out        rsp_valid strobe, one cycle
//   csr       psel, penable, pwrite, paddr, ...  in/out     APB write, pready tied high
//
// One texel is accepted every clock; busy never rises. Each result passes through twenty
// register stages before it is on the ports, namely three setup stages (vector, squares,
// norm), sixteen stages of the code search (multiply and compare for each of eight bits)
// and the output register.
// Reset is synchronous and clears the valid line and face_size; no stall exists on
// either side, so the pipeline advances every cycle.
`default_nettype none

module normalization_cubemap_texel_core #(
   parameter int MAX_FACE_SIZE = ncm_pkg::DEFAULT_MAX_FACE_SIZE
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [2:0]   req_face,
   input  logic [9:0]   req_column,
   input  logic [9:0]   req_row,
   output logic         rsp_valid,
   output logic [7:0]   rsp_red,
   output logic [7:0]   rsp_green,
   output logic [7:0]   rsp_blue,
   output logic [7:0]   rsp_alpha,
   output logic         rsp_coord_error,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   import ncm_pkg::*;

   localparam int SW   = $clog2(MAX_FACE_SIZE + 1);
   localparam int VW   = SW + 1;
   localparam int EW   = (SW > FACE_SIZE_W) ? SW : FACE_SIZE_W;
   localparam int CW   = ((SW > 11) ? SW : 11) + 1;
   localparam int SQW  = 2 * SW;
   localparam int QW   = SQW + 2;
   localparam int A2W  = SQW + 16;
   localparam int LANES = 3;

   localparam logic [2:0] FACE_POS_X = 3'd0;
   localparam logic [2:0] FACE_NEG_X = 3'd1;
   localparam logic [2:0] FACE_POS_Y = 3'd2;
   localparam logic [2:0] FACE_NEG_Y = 3'd3;
   localparam logic [2:0] FACE_POS_Z = 3'd4;
   localparam logic [2:0] FACE_NEG_Z = 3'd5;

   localparam logic CSR_FACE_SIZE = 1'b0;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic face_bad;
      logic coord_bad;
   } texel_flags_type;

   logic [FACE_SIZE_W-1:0] face_size_ff;

   logic                   s1_valid_ff;
   texel_flags_type        s1_flags_ff;
   logic signed [VW-1:0]   s1_v_ff [LANES];

   logic                   s2_valid_ff;
   texel_flags_type        s2_flags_ff;
   logic [SQW-1:0]         s2_sq_ff [LANES];
   logic                   s2_neg_ff [LANES];

   logic                   s3_valid_ff;
   texel_flags_type        s3_flags_ff;
   logic [QW-1:0]          s3_q_ff;
   logic [A2W-1:0]         s3_a2_ff [LANES];
   logic                   s3_neg_ff [LANES];

   logic                   dl_valid_ff [ENC_STAGES];
   texel_flags_type        dl_flags_ff [ENC_STAGES];

   logic                   rsp_valid_ff;
   logic [7:0]             rsp_red_ff;
   logic [7:0]             rsp_green_ff;
   logic [7:0]             rsp_blue_ff;
   logic [7:0]             rsp_alpha_ff;
   logic                   rsp_coord_error_ff;

   logic                   accept;
   logic                   csr_write;
   logic [EW-1:0]          size_ext;
   logic [SW-1:0]          size_eff;
   logic [CW-1:0]          col_ext;
   logic [CW-1:0]          row_ext;
   logic [CW-1:0]          size_cw;
   logic [CW-1:0]          a_full;
   logic [CW-1:0]          b_full;
   logic signed [VW-1:0]   a_v;
   logic signed [VW-1:0]   b_v;
   logic signed [VW-1:0]   unit_v;
   texel_flags_type        s1_flags_in;
   logic signed [VW-1:0]   s1_v_in [LANES];
   logic [SQW-1:0]         s2_sq_in [LANES];
   logic [QW-1:0]          s3_q_in;
   logic [A2W-1:0]         s3_a2_in [LANES];
   logic [CODE_BITS-1:0]   code [LANES];
   texel_flags_type        out_flags;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign accept = start && !busy;

   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == CSR_FACE_SIZE);
   assign prdata    = (paddr[2] == CSR_FACE_SIZE) ? 32'(face_size_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff <= FACE_SIZE_RESET;
      end else if (csr_write) begin
         face_size_ff <= pwdata[FACE_SIZE_W-1:0];
      end
   end

   // Stage 1: saturate the size, check the coordinates and build the face vector.
   always_comb begin
      size_ext = EW'(face_size_ff);
      size_eff = (size_ext > EW'(MAX_FACE_SIZE)) ? SW'(MAX_FACE_SIZE) : SW'(size_ext);
      col_ext  = CW'(req_column);
      row_ext  = CW'(req_row);
      size_cw  = CW'(size_eff);
      a_full   = (col_ext << 1) - size_cw;
      b_full   = (row_ext << 1) - size_cw;
      a_v      = signed'(a_full[VW-1:0]);
      b_v      = signed'(b_full[VW-1:0]);
      unit_v   = signed'({1'b0, size_eff});
      s1_flags_in.coord_bad = (col_ext >= size_cw) || (row_ext >= size_cw);
      s1_flags_in.face_bad  = 1'b0;
      unique case (req_face)
         FACE_POS_X: begin
            s1_v_in[0] = unit_v;  s1_v_in[1] = -b_v;     s1_v_in[2] = -a_v;
         end
         FACE_NEG_X: begin
            s1_v_in[0] = -unit_v; s1_v_in[1] = -b_v;     s1_v_in[2] = a_v;
         end
         FACE_POS_Y: begin
            s1_v_in[0] = a_v;     s1_v_in[1] = unit_v;   s1_v_in[2] = b_v;
         end
         FACE_NEG_Y: begin
            s1_v_in[0] = a_v;     s1_v_in[1] = -unit_v;  s1_v_in[2] = -b_v;
         end
         FACE_POS_Z: begin
            s1_v_in[0] = a_v;     s1_v_in[1] = -b_v;     s1_v_in[2] = unit_v;
         end
         FACE_NEG_Z: begin
            s1_v_in[0] = -a_v;    s1_v_in[1] = -b_v;     s1_v_in[2] = -unit_v;
         end
         default: begin
            s1_v_in[0] = '0;      s1_v_in[1] = '0;       s1_v_in[2] = '0;
            s1_flags_in.face_bad = 1'b1;
         end
      endcase
   end

   // Stage 2 squares each component; stage 3 sums the norm and scales by 255 squared.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         s2_sq_in[l] = SQW'(s1_v_ff[l] * s1_v_ff[l]);
         s3_a2_in[l] = (A2W'(s2_sq_ff[l]) << 16) - (A2W'(s2_sq_ff[l]) << 9)
                       + A2W'(s2_sq_ff[l]);
      end
      s3_q_in = QW'(s2_sq_ff[0]) + QW'(s2_sq_ff[1]) + QW'(s2_sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      s1_flags_ff <= s1_flags_in;
      s2_flags_ff <= s1_flags_ff;
      s3_flags_ff <= s2_flags_ff;
      s3_q_ff     <= s3_q_in;
      for (int l = 0; l < LANES; l++) begin
         s1_v_ff[l]   <= s1_v_in[l];
         s2_sq_ff[l]  <= s2_sq_in[l];
         s2_neg_ff[l] <= s1_v_ff[l][VW-1];
         s3_a2_ff[l]  <= s3_a2_in[l];
         s3_neg_ff[l] <= s2_neg_ff[l];
      end
      dl_flags_ff[0] <= s3_flags_ff;
      for (int j = 1; j < ENC_STAGES; j++) begin
         dl_flags_ff[j] <= dl_flags_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         for (int j = 0; j < ENC_STAGES; j++) begin
            dl_valid_ff[j] <= 1'b0;
         end
      end else begin
         s1_valid_ff    <= accept;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         dl_valid_ff[0] <= s3_valid_ff;
         for (int j = 1; j < ENC_STAGES; j++) begin
            dl_valid_ff[j] <= dl_valid_ff[j-1];
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      ncm_encoder #(
         .Q_WIDTH  (QW),
         .A2_WIDTH (A2W)
      ) u_encoder (
         .clock    (clock),
         .in_q     (s3_q_ff),
         .in_a2    (s3_a2_ff[l]),
         .in_neg   (s3_neg_ff[l]),
         .out_code (code[l])
      );
   end

   assign out_flags = dl_flags_ff[ENC_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dl_valid_ff[ENC_STAGES-1];
      end
   end

   // A bad face clears everything; a bad coordinate on a good face raises the error flag.
   always_ff @(posedge clock) begin
      if (out_flags.face_bad || out_flags.coord_bad) begin
         rsp_red_ff         <= '0;
         rsp_green_ff       <= '0;
         rsp_blue_ff        <= '0;
         rsp_alpha_ff       <= '0;
         rsp_coord_error_ff <= !out_flags.face_bad;
      end else begin
         rsp_red_ff         <= code[0];
         rsp_green_ff       <= code[1];
         rsp_blue_ff        <= code[2];
         rsp_alpha_ff       <= ALPHA_OPAQUE;
         rsp_coord_error_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red         = rsp_red_ff;
   assign rsp_green       = rsp_green_ff;
   assign rsp_blue        = rsp_blue_ff;
   assign rsp_alpha       = rsp_alpha_ff;
   assign rsp_coord_error = rsp_coord_error_ff;

endmodule

`default_nettype wire

// ----- sv/ncm_encoder.sv -----
// Pipelined bit-by-bit search that turns one normal component into its rounded color code.
`default_nettype none

module ncm_encoder #(
   parameter int Q_WIDTH = 2 * $clog2(ncm_pkg::DEFAULT_MAX_FACE_SIZE + 1) + 2,
   parameter int A2_WIDTH = 2 * $clog2(ncm_pkg::DEFAULT_MAX_FACE_SIZE + 1) + 16
) (
   input  logic                           clock,
   input  logic [Q_WIDTH-1:0]             in_q,
   input  logic [A2_WIDTH-1:0]            in_a2,
   input  logic                           in_neg,
   output logic [ncm_pkg::CODE_BITS-1:0]  out_code
);
   import ncm_pkg::*;

   localparam int P_WIDTH = Q_WIDTH + BSQ_W;
   localparam int LAST = CODE_BITS - 1;

   // Multiply stage registers, one set per code bit.
   logic [CODE_BITS-1:0] m_cand_ff [CODE_BITS];
   logic [P_WIDTH-1:0]   m_prod_ff [CODE_BITS];
   logic [A2_WIDTH-1:0]  m_a2_ff   [CODE_BITS];
   logic                 m_neg_ff  [CODE_BITS];
   logic [Q_WIDTH-1:0]   m_q_ff    [LAST];

   // Compare stage registers.
   logic [CODE_BITS-1:0] c_code_ff [CODE_BITS];
   logic [Q_WIDTH-1:0]   c_q_ff    [LAST];
   logic [A2_WIDTH-1:0]  c_a2_ff   [LAST];
   logic                 c_neg_ff  [LAST];

   logic [CODE_BITS-1:0] s_code    [CODE_BITS];
   logic [Q_WIDTH-1:0]   s_q       [CODE_BITS];
   logic [A2_WIDTH-1:0]  s_a2      [CODE_BITS];
   logic                 s_neg     [CODE_BITS];
   logic [CODE_BITS-1:0] bit_mask  [CODE_BITS];
   logic [CODE_BITS-1:0] m_cand_in [CODE_BITS];
   logic [P_WIDTH-1:0]   m_prod_in [CODE_BITS];
   logic [P_WIDTH-1:0]   a2_ext    [CODE_BITS];
   logic                 hit       [CODE_BITS];
   logic [CODE_BITS-1:0] c_code_in [CODE_BITS];

   always_comb begin
      s_code[0] = '0;
      s_q[0]    = in_q;
      s_a2[0]   = in_a2;
      s_neg[0]  = in_neg;
      for (int i = 1; i < CODE_BITS; i++) begin
         s_code[i] = c_code_ff[i-1];
         s_q[i]    = c_q_ff[i-1];
         s_a2[i]   = c_a2_ff[i-1];
         s_neg[i]  = c_neg_ff[i-1];
      end
   end

   // The code is the largest m for which 255*v >= (2m-256)*sqrt(q) holds. Bits are
   // settled from the top down; the test compares squares so it stays exact.
   always_comb begin
      for (int i = 0; i < CODE_BITS; i++) begin
         bit_mask[i]  = CODE_BITS'(1) << (LAST - i);
         m_cand_in[i] = s_code[i] | bit_mask[i];
         m_prod_in[i] = BTERM_SQ[m_cand_in[i]] * s_q[i];
         a2_ext[i]    = P_WIDTH'(m_a2_ff[i]);
         if (m_cand_ff[i] <= HALF_CODE) begin
            hit[i] = !m_neg_ff[i] || (a2_ext[i] <= m_prod_ff[i]);
         end else begin
            hit[i] = !m_neg_ff[i] && (a2_ext[i] >= m_prod_ff[i]);
         end
         c_code_in[i] = hit[i] ? m_cand_ff[i] : (m_cand_ff[i] & ~bit_mask[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CODE_BITS; i++) begin
         m_cand_ff[i] <= m_cand_in[i];
         m_prod_ff[i] <= m_prod_in[i];
         m_a2_ff[i]   <= s_a2[i];
         m_neg_ff[i]  <= s_neg[i];
         c_code_ff[i] <= c_code_in[i];
      end
      for (int i = 0; i < LAST; i++) begin
         m_q_ff[i]   <= s_q[i];
         c_q_ff[i]   <= m_q_ff[i];
         c_a2_ff[i]  <= m_a2_ff[i];
         c_neg_ff[i] <= m_neg_ff[i];
      end
   end

   assign out_code = c_code_ff[LAST];

endmodule

`default_nettype wire
